### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers used by the interpolator top
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge, off while in reset
`define ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// condition followed by another in the next cycle
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### src/apint_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apint_pkg
// shared widths, codes and types of the axis position interpolator
// ---------------------------------------------------------------------------
package apint_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int SW_W      = 8;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CNT_W     = $clog2(DATA_W);
	localparam int TICK_RATE = 32000;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic [SW_W-1:0]          sw_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	// command codes
	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_MOVE = 2'd1,
		OP_JOG  = 2'd2,
		OP_SET  = 2'd3
	} op_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STOP_MASK  = 2'd0,
		CFG_UPPER_MASK = 2'd1,
		CFG_LOWER_MASK = 2'd2
	} cfg_idx_t;

	// status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

### src/apint_cmd_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apint_cmd_if
// command channel: valid/ready handshake with the command fields
// ---------------------------------------------------------------------------
interface apint_cmd_if;

	logic                  valid;
	logic                  ready;
	logic [1:0]            op;
	apint_pkg::word_t      position_value;
	apint_pkg::word_t      duration;
	apint_pkg::word_t      jog_rate;
	apint_pkg::sw_t        limit_switches;

	modport source (
		output valid, op, position_value, duration, jog_rate, limit_switches,
		input  ready
	);

	modport sink (
		input  valid, op, position_value, duration, jog_rate, limit_switches,
		output ready
	);

endinterface

### src/apint_res_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apint_res_if
// result channel: valid/ready handshake with position and velocity
// ---------------------------------------------------------------------------
interface apint_res_if;

	logic             valid;
	logic             ready;
	apint_pkg::word_t position_now;
	apint_pkg::word_t velocity_now;

	modport source (
		output valid, position_now, velocity_now,
		input  ready
	);

	modport sink (
		input  valid, position_now, velocity_now,
		output ready
	);

endinterface

### src/apint_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apint_mul
// bit-serial signed shift-add multiplier, one multiplier bit per cycle
// ---------------------------------------------------------------------------
module apint_mul #(
	parameter int ACC_W = 52
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [ACC_W-1:0]      mcand,
	input  apint_pkg::word_t             mplier,
	output logic        [ACC_W-1:0]      product,
	output apint_pkg::unit_stat_t        stat
);

	localparam apint_pkg::cnt_t LAST = apint_pkg::cnt_t'(apint_pkg::DATA_W - 1);

	logic                 busy_q;
	logic                 done_q;
	apint_pkg::cnt_t      cnt_q;
	logic [ACC_W-1:0]     mcand_q;
	apint_pkg::word_t     mplier_q;
	logic [ACC_W-1:0]     acc_q;
	logic [ACC_W-1:0]     addend;
	logic [ACC_W-1:0]     acc_nx;

	// the top multiplier bit carries negative weight
	always_comb begin
		addend = (cnt_q == LAST) ? (~mcand_q + ACC_W'(1)) : mcand_q;
		acc_nx = mplier_q[0] ? (acc_q + addend) : acc_q;
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + apint_pkg::cnt_t'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand shift registers and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			acc_q    <= '0;
		end else if (busy_q) begin
			acc_q    <= acc_nx;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >>> 1;
		end
	end

	assign product   = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### src/apint_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apint_div
// bit-serial restoring divider, one quotient bit per cycle, truncating
// toward zero for a signed dividend and a positive divisor
// ---------------------------------------------------------------------------
module apint_div #(
	parameter int DEN_W = 36
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  apint_pkg::word_t        num,
	input  logic [DEN_W-1:0]        den,
	output apint_pkg::word_t        quot,
	output apint_pkg::unit_stat_t   stat
);

	localparam int DW = apint_pkg::DATA_W;
	localparam apint_pkg::cnt_t LAST = apint_pkg::cnt_t'(DW - 1);

	logic               busy_q;
	logic               done_q;
	apint_pkg::cnt_t    cnt_q;
	logic [DW-1:0]      dq_q;
	logic [DEN_W-1:0]   rem_q;
	logic [DEN_W-1:0]   den_q;
	logic               neg_q;
	logic [DW-1:0]      num_mag;
	logic [DEN_W:0]     shifted;
	logic [DEN_W+1:0]   diff;
	logic               fits;

	// magnitude of the dividend and one trial subtraction
	always_comb begin
		num_mag = num[DW-1] ? (~num + DW'(1)) : num;
		shifted = {rem_q, dq_q[DW-1]};
		diff    = {1'b0, shifted} - {2'b00, den_q};
		fits    = !diff[DEN_W+1];
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + apint_pkg::cnt_t'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out while quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= num_mag;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[DW-1];
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			dq_q  <= {dq_q[DW-2:0], fits};
		end
	end

	assign quot      = neg_q ? (~dq_q + DW'(1)) : dq_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### src/axis_position_interpolator_top.sv
`timescale 1ns / 1ps
// Single-axis constant-velocity interpolator. One command is in flight at a
// time and each gives one result. Tick and set-position commands, and a move
// with a duration of zero or less, pass from acceptance straight to the done
// state, which loads their result into the output register. A move with a
// positive duration, or a jog, first passes through 32 steps of the bit-serial
// shift-add multiplier (tick count or jog distance), then 32 steps of the
// bit-serial restoring divider (velocity), before the done state loads its
// result. A result that waits on the output delays the load until it is
// taken. A new command is taken as soon as the previous result is loaded into
// the output register, even while that result still waits.
// ---------------------------------------------------------------------------
// axis_position_interpolator_top
// position, target and velocity registers with serial mul/div datapath
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module axis_position_interpolator_top #(
	parameter int TICK_RATE = apint_pkg::TICK_RATE
) (
	input  logic                               clk,
	input  logic                               arst_n,
	apint_cmd_if.sink                          cmd,
	apint_res_if.source                        res,
	input  logic                               cfg_we,
	input  logic [apint_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [apint_pkg::CFG_W-1:0]        cfg_data
);

	localparam int DW    = apint_pkg::DATA_W;
	localparam int FW    = apint_pkg::FRAC_W;
	localparam int TR_W  = $clog2(TICK_RATE + 1);
	localparam int ACC_W = DW + ((TR_W > FW) ? TR_W : FW);
	localparam int DEN_W = ACC_W - FW;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic                    out_valid_q;
	apint_pkg::word_t        pos_out_q;
	apint_pkg::word_t        vel_out_q;
	apint_pkg::word_t        position_q;
	apint_pkg::word_t        target_q;
	apint_pkg::word_t        velocity_q;
	apint_pkg::sw_t          stop_mask_q;
	apint_pkg::sw_t          upper_mask_q;
	apint_pkg::sw_t          lower_mask_q;

	apint_pkg::op_t          op_q;
	apint_pkg::word_t        pval_q;
	apint_pkg::word_t        rate_q;
	apint_pkg::sw_t          sw_q;
	logic                    dur_pos_q;
	apint_pkg::word_t        dist_q;

	logic                    accept;
	apint_pkg::op_t          cmd_op;
	logic                    dur_pos;
	logic                    mul_start;
	logic signed [ACC_W-1:0] mul_mcand;
	logic [ACC_W-1:0]        mul_product;
	apint_pkg::unit_stat_t   mul_stat;
	logic [DEN_W-1:0]        ticks;
	logic                    div_start;
	apint_pkg::word_t        div_num;
	logic [DEN_W-1:0]        div_den;
	apint_pkg::word_t        div_quot;
	apint_pkg::unit_stat_t   div_stat;

	logic                    commit;
	logic                    fwd;
	apint_pkg::sw_t          lim;
	apint_pkg::word_t        pos_nx;
	apint_pkg::word_t        tgt_nx;
	apint_pkg::word_t        vel_nx;

	// command handshake
	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign cmd_op    = apint_pkg::op_t'(cmd.op);
	assign dur_pos   = !cmd.duration[DW-1] && (cmd.duration != '0);

	// multiplier: tick count for a move, distance for a jog
	assign mul_start = accept &&
		((cmd_op == apint_pkg::OP_JOG) || ((cmd_op == apint_pkg::OP_MOVE) && dur_pos));
	assign mul_mcand = (cmd_op == apint_pkg::OP_MOVE) ? ACC_W'(TICK_RATE)
		: ACC_W'(cmd.jog_rate);

	apint_mul #(
		.ACC_W (ACC_W)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mul_mcand),
		.mplier  (cmd.duration),
		.product (mul_product),
		.stat    (mul_stat)
	);

	// divider: distance over ticks for a move, rate over tick rate for a jog
	assign ticks     = mul_product[ACC_W-1:FW];
	assign div_start = (state_q == S_MUL) && mul_stat.done;
	assign div_num   = (op_q == apint_pkg::OP_MOVE) ? (pval_q - position_q) : rate_q;
	assign div_den   = (op_q != apint_pkg::OP_MOVE) ? DEN_W'(TICK_RATE)
		: ((ticks == '0) ? DEN_W'(1) : ticks);

	apint_div #(
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quot   (div_quot),
		.stat   (div_stat)
	);

	// axis update applied when the result is loaded
	assign commit = (state_q == S_DONE) && (!out_valid_q || res.ready);
	assign fwd    = !velocity_q[DW-1];
	assign lim    = fwd ? upper_mask_q : lower_mask_q;

	always_comb begin
		pos_nx = position_q;
		tgt_nx = target_q;
		vel_nx = velocity_q;
		unique case (op_q)
			apint_pkg::OP_TICK: begin
				if ((lim & sw_q & stop_mask_q) != '0) begin
					vel_nx = '0;
				end else if (fwd ? (target_q > position_q) : (target_q < position_q)) begin
					pos_nx = position_q + velocity_q;
				end else begin
					pos_nx = target_q;
					vel_nx = '0;
				end
			end
			apint_pkg::OP_MOVE: begin
				tgt_nx = pval_q;
				vel_nx = dur_pos_q ? div_quot : '0;
			end
			apint_pkg::OP_JOG: begin
				tgt_nx = position_q + dist_q;
				vel_nx = div_quot;
			end
			apint_pkg::OP_SET: begin
				pos_nx = pval_q;
			end
		endcase
	end

	// control state machine, axis state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			pos_out_q   <= '0;
			vel_out_q   <= '0;
			position_q  <= '0;
			target_q    <= '0;
			velocity_q  <= '0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
				pos_out_q   <= pos_nx;
				vel_out_q   <= vel_nx;
				position_q  <= pos_nx;
				target_q    <= tgt_nx;
				velocity_q  <= vel_nx;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (accept) state_q <= mul_start ? S_MUL : S_DONE;
				S_MUL:  if (mul_stat.done) state_q <= S_DIV;
				S_DIV:  if (div_stat.done) state_q <= S_DONE;
				S_DONE: if (commit) state_q <= S_IDLE;
			endcase
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_mask_q  <= '0;
			upper_mask_q <= '0;
			lower_mask_q <= '0;
		end else if (cfg_we) begin
			case (apint_pkg::cfg_idx_t'(cfg_index))
				apint_pkg::CFG_STOP_MASK:  stop_mask_q  <= cfg_data;
				apint_pkg::CFG_UPPER_MASK: upper_mask_q <= cfg_data;
				apint_pkg::CFG_LOWER_MASK: lower_mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// command fields held for the duration of the transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= cmd_op;
			pval_q    <= cmd.position_value;
			rate_q    <= cmd.jog_rate;
			sw_q      <= cmd.limit_switches;
			dur_pos_q <= dur_pos;
		end
		if (mul_stat.done) begin
			dist_q <= mul_product[DW+FW-1:FW];
		end
	end

	// result channel
	assign res.valid        = out_valid_q;
	assign res.position_now = pos_out_q;
	assign res.velocity_now = vel_out_q;

	// checks
	`ASSERT_IMPL(a_idle_units, cmd.ready, !mul_stat.busy && !div_stat.busy,
		"command taken while a serial unit is busy")
	`ASSERT_IMPL(a_div_nonzero, div_start, div_den != '0,
		"divider started with a zero divisor")
	`ASSERT_NEXT(a_commit_valid, commit, res.valid && (res.position_now == position_q),
		"loaded result does not match axis position")
	`ASSERT_IMPL(a_move_rest, commit && (op_q == apint_pkg::OP_MOVE) && !dur_pos_q,
		vel_nx == '0, "move without positive duration gives nonzero velocity")

endmodule

### tb/sv/axis_position_interpolator_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// axis_position_interpolator_checker
// watches the command, result and register ports, keeps its own copy of the
// axis state and compares every result transaction with the predicted one
// ---------------------------------------------------------------------------
module axis_position_interpolator_checker
	import apint_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	apint_cmd_if                 cmd,
	apint_res_if                 res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   pending,
	output int                   compared
);

	typedef struct {
		word_t pos;
		word_t vel;
	} motion_t;

	// predicted axis state and switch masks
	word_t axis_pos;
	word_t axis_tgt;
	word_t axis_vel;
	sw_t   stop_bits;
	sw_t   upper_bits;
	sw_t   lower_bits;

	motion_t motion_q[$];
	motion_t want;
	int      fail_ct;
	int      cmp_ct;

	// apply one command to the predicted state and queue the expected result
	task automatic step_axis(input op_t op, input word_t pval, input word_t dur,
			input word_t rate, input sw_t sw);
		longint      ticks;
		longint      span;
		longint      quo;
		logic [63:0] prod;
		word_t       diff;
		word_t       jog_dist;
		logic        fwd;
		sw_t         lim;
		motion_t     m;
		case (op)
			OP_MOVE: begin
				quo = 0;
				if (dur > 0) begin
					ticks = (longint'(TICK_RATE) * longint'(dur)) >>> FRAC_W;
					diff  = pval - axis_pos;
					span  = diff;
					// a move shorter than one tick still takes one
					if (ticks < 1)
						ticks = 1;
					quo = span / ticks;
				end
				axis_tgt = pval;
				axis_vel = quo[31:0];
			end
			OP_JOG: begin
				prod     = longint'(rate) * longint'(dur);
				jog_dist = prod[47:16];
				axis_tgt = axis_pos + jog_dist;
				quo      = longint'(rate) / longint'(TICK_RATE);
				axis_vel = quo[31:0];
			end
			OP_SET: begin
				axis_pos = pval;
			end
			default: begin
				// at rest counts as forward travel
				fwd = (axis_vel >= 0);
				lim = fwd ? upper_bits : lower_bits;
				if ((lim & sw & stop_bits) != '0) begin
					axis_vel = '0;
				end else if (fwd ? (axis_tgt > axis_pos) : (axis_tgt < axis_pos)) begin
					axis_pos = axis_pos + axis_vel;
				end else begin
					axis_pos = axis_tgt;
					axis_vel = '0;
				end
			end
		endcase
		m.pos = axis_pos;
		m.vel = axis_vel;
		motion_q.push_back(m);
	endtask

	// compare results, then predict the accepted command
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_pos   = '0;
			axis_tgt   = '0;
			axis_vel   = '0;
			stop_bits  = '0;
			upper_bits = '0;
			lower_bits = '0;
			motion_q.delete();
			fail_ct    = 0;
			cmp_ct     = 0;
			fail_count <= 0;
			pending    <= 0;
			compared   <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (motion_q.size() == 0) begin
					$error("result transaction with no expected result: position_now %0d, velocity_now %0d",
						res.position_now, res.velocity_now);
					fail_ct++;
				end else begin
					want = motion_q.pop_front();
					cmp_ct++;
					if (res.position_now !== want.pos) begin
						$error("position_now: expected %0d, actual %0d", want.pos, res.position_now);
						fail_ct++;
					end
					if (res.velocity_now !== want.vel) begin
						$error("velocity_now: expected %0d, actual %0d", want.vel, res.velocity_now);
						fail_ct++;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				step_axis(op_t'(cmd.op), cmd.position_value, cmd.duration, cmd.jog_rate,
					cmd.limit_switches);
			// register writes, only issued while idle
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_STOP_MASK:  stop_bits  = cfg_data;
					CFG_UPPER_MASK: upper_bits = cfg_data;
					CFG_LOWER_MASK: lower_bits = cfg_data;
					default: ;
				endcase
			end
			fail_count <= fail_ct;
			pending    <= motion_q.size();
			compared   <= cmp_ct;
		end
	end

endmodule

### tb/sv/axis_position_interpolator_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// axis_position_interpolator_top_tb
// drives directed and random motion commands through the interpolator under
// several switch mask settings with random stalls on both channels; the
// checker beside the block predicts and compares every result
// ---------------------------------------------------------------------------
module axis_position_interpolator_top_tb;
	import apint_pkg::*;

	localparam int RANDOM_ITEMS = 1070;
	localparam int SEGMENTS     = 6;
	localparam int HOLD_AFTER   = 300;
	localparam int HOLD_CYCLES  = 600;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int fail_count;
	int pending;
	int compared;

	int n_items;
	int n_mask_sets;
	int burst_left;
	int op_count[4];

	apint_cmd_if cmd_ch ();
	apint_res_if res_ch ();

	axis_position_interpolator_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	axis_position_interpolator_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.res        (res_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.compared   (compared)
	);

	// 20 ns clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// offer one command transaction after a random gap, return once accepted
	task automatic send(input op_t op, input word_t pval, input word_t dur,
			input word_t rate, input sw_t sw);
		int gap;
		int r;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				burst_left = $urandom_range(30, 120);
				gap = 0;
			end else if (r < 75) begin
				gap = 0;
			end else if (r < 95) begin
				gap = $urandom_range(1, 3);
			end else begin
				gap = $urandom_range(20, 80);
			end
		end
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid          <= 1'b1;
		cmd_ch.op             <= op;
		cmd_ch.position_value <= pval;
		cmd_ch.duration       <= dur;
		cmd_ch.jog_rate       <= rate;
		cmd_ch.limit_switches <= sw;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		op_count[op]++;
		n_items++;
	endtask

	// write all three switch masks on consecutive edges
	task automatic set_masks(input sw_t stop, input sw_t upper, input sw_t lower);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_STOP_MASK;
		cfg_data  <= stop;
		@(posedge clk);
		cfg_index <= CFG_UPPER_MASK;
		cfg_data  <= upper;
		@(posedge clk);
		cfg_index <= CFG_LOWER_MASK;
		cfg_data  <= lower;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_mask_sets++;
	endtask

	// stop offering and wait until every expected result is in
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// result side: random stalls, quiet stretches and one long hold
	initial begin : rx_side
		int   taken;
		int   hold_left;
		int   gap_left;
		int   calm_left;
		int   r;
		bit   held;
		logic nxt;
		taken     = 0;
		hold_left = 0;
		gap_left  = 0;
		calm_left = 0;
		held      = 1'b0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				taken++;
			if (hold_left > 0) begin
				hold_left--;
				nxt = 1'b0;
			end else if (!held && taken >= HOLD_AFTER) begin
				// long hold so the block fills and stalls its command input
				held      = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				nxt       = 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				nxt = 1'b0;
			end else if (calm_left > 0) begin
				calm_left--;
				nxt = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				nxt = 1'b1;
				if (r < 5) begin
					calm_left = $urandom_range(50, 200);
				end else if (r < 75) begin
					nxt = 1'b1;
				end else if (r < 95) begin
					gap_left = $urandom_range(0, 2);
					nxt = 1'b0;
				end else begin
					gap_left = $urandom_range(19, 79);
					nxt = 1'b0;
				end
			end
			res_ch.ready <= nxt;
		end
	end

	// stimulus and verdict
	initial begin : stim
		int seg;
		int n_dir;
		int n_ticks;
		int k;
		word_t pval;
		word_t dur;
		word_t rate;
		n_items     = 0;
		n_mask_sets = 0;
		burst_left  = 0;
		foreach (op_count[i]) op_count[i] = 0;
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_index             <= CFG_STOP_MASK;
		cfg_data              <= '0;
		cmd_ch.valid          <= 1'b0;
		cmd_ch.op             <= OP_TICK;
		cmd_ch.position_value <= '0;
		cmd_ch.duration       <= '0;
		cmd_ch.jog_rate       <= '0;
		cmd_ch.limit_switches <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: wrap, duration corners, jog extremes, limit stops
		set_masks(8'hFF, 8'h01, 8'h02);
		send(OP_SET,  32'h7FFF_FFF0, 32'd0, 32'd0, 8'h00);
		send(OP_MOVE, 32'h8000_0010, 32'd8, 32'd0, 8'h00);
		send(OP_TICK, 32'd0, 32'd0, 32'd0, 8'h00);
		send(OP_TICK, 32'd0, 32'd0, 32'd0, 8'h00);
		send(OP_MOVE, 32'd5000, 32'd0, 32'd0, 8'h00);
		send(OP_MOVE, 32'd7000, 32'h8000_0000, 32'd0, 8'h00);
		send(OP_SET,  32'd0, 32'd0, 32'd0, 8'h00);
		send(OP_MOVE, 32'd1000, 32'd1, 32'd0, 8'h00);
		send(OP_TICK, 32'd0, 32'd0, 32'd0, 8'h00);
		send(OP_TICK, 32'd0, 32'd0, 32'd0, 8'h00);
		send(OP_MOVE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 8'h00);
		send(OP_JOG,  32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h00);
		send(OP_JOG,  32'd0, 32'd3, 32'h8000_0000, 8'h00);
		send(OP_JOG,  32'd0, 32'd16, -32'sd64000, 8'h00);
		send(OP_TICK, 32'd0, 32'd0, 32'd0, 8'h02);
		send(OP_JOG,  32'd0, 32'd16, -32'sd64000, 8'h00);
		send(OP_TICK, 32'd0, 32'd0, 32'd0, 8'h01);
		send(OP_TICK, 32'd0, 32'd0, 32'd0, 8'hFF);
		send(OP_TICK, 32'd0, 32'd0, 32'd0, 8'h01);
		send(OP_SET,  32'h8000_0000, 32'd0, 32'd0, 8'h00);
		send(OP_SET,  32'h7FFF_FFFF, 32'd0, 32'd0, 8'h00);
		send(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		drain();
		n_dir = n_items;

		// random segments, each under its own mask setting
		for (seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: set_masks(8'h00, 8'h00, 8'h00);
				1: set_masks(8'hFF, 8'hFF, 8'hFF);
				2: set_masks(8'hFF, 8'h0F, 8'hF0);
				4: set_masks(8'hFF, 8'hAA, 8'h55);
				default: set_masks(sw_t'($urandom), sw_t'($urandom), sw_t'($urandom));
			endcase
			while (n_items < n_dir + (seg + 1) * RANDOM_ITEMS / SEGMENTS) begin
				if ($urandom_range(0, 99) < 80) begin
					// well-formed motion: optional set, a move or jog, then ticks
					if ($urandom_range(0, 9) < 3) begin
						pval = $urandom_range(0, 1) ? $urandom
							: $urandom_range(0, 200000) - 100000;
						send(OP_SET, pval, $urandom, $urandom, sw_t'($urandom));
					end
					if ($urandom_range(0, 99) < 55) begin
						pval = $urandom_range(0, 1) ? $urandom
							: $urandom_range(0, 200000) - 100000;
						k = $urandom_range(0, 99);
						if (k < 70)
							dur = $urandom_range(1, 48);
						else if (k < 85)
							dur = $urandom & 32'h7FFF_FFFF;
						else if (k < 95)
							dur = $urandom | 32'h8000_0000;
						else
							dur = '0;
						send(OP_MOVE, pval, dur, $urandom, sw_t'($urandom));
					end else begin
						rate = ($urandom_range(0, 1)) ? $urandom
							: $urandom_range(0, 6400000) - 3200000;
						dur = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 48) : $urandom;
						send(OP_JOG, $urandom, dur, rate, sw_t'($urandom));
					end
					n_ticks = $urandom_range(1, 30);
					repeat (n_ticks)
						send(OP_TICK, $urandom, $urandom, $urandom,
							($urandom_range(0, 99) < 70) ? 8'h00 : sw_t'($urandom));
				end else begin
					send(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
						sw_t'($urandom));
				end
			end
			drain();
		end

		repeat (80) @(posedge clk);
		$display("run covered %0d commands: %0d ticks, %0d moves, %0d jogs, %0d position sets",
			n_items, op_count[OP_TICK], op_count[OP_MOVE], op_count[OP_JOG], op_count[OP_SET]);
		$display("%0d results compared over %0d switch mask settings, with a long result stall",
			compared, n_mask_sets);
		if (fail_count == 0 && pending == 0)
			$display("axis_position_interpolator_top regression: pass");
		else
			$display("axis_position_interpolator_top regression: fail");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("axis_position_interpolator_top regression: fail");
		$finish;
	end

endmodule
